[rtl/chkb_pkg.sv]
`timescale 1ns / 1ps
// Package for the cubic Hermite keyframe blend.
// Holds widths, payload structs and the sequencer state type; no dependencies.
package chkb_pkg;

	localparam int ValW     = 32;
	localparam int FracW    = 16;
	localparam int PhW      = FracW + 1;
	localparam int WgtW     = 20;
	localparam int MulW     = 34;
	localparam int ProdW    = 2 * MulW;
	localparam int SumW     = 2 * ValW + 1;
	localparam int RootW    = ValW + 1;
	localparam int NumW     = ValW + FracW + 1;
	localparam int DivSteps = FracW + 1;
	localparam int StepW    = 6;

	localparam logic [PhW-1:0] PhOne = PhW'(1) << FracW;

	typedef struct packed {
		logic signed [ValW-1:0] start_value;
		logic signed [ValW-1:0] out_tangent;
		logic signed [ValW-1:0] end_value;
		logic signed [ValW-1:0] in_tangent;
		logic [ValW-1:0]        tangent_scale;
		logic [PhW-1:0]         phase;
		logic                   is_rotation;
	} in_item_t;

	typedef struct packed {
		logic signed [ValW-1:0] value;
		logic                   last;
		logic                   zero_norm;
	} out_item_t;

	typedef enum logic [11:0] {
		S_IDLE = 12'b0000_0000_0001,
		S_T2   = 12'b0000_0000_0010,
		S_T3   = 12'b0000_0000_0100,
		S_P0   = 12'b0000_0000_1000,
		S_P1   = 12'b0000_0001_0000,
		S_M0   = 12'b0000_0010_0000,
		S_M1   = 12'b0000_0100_0000,
		S_SC   = 12'b0000_1000_0000,
		S_SQ   = 12'b0001_0000_0000,
		S_ROOT = 12'b0010_0000_0000,
		S_DIV  = 12'b0100_0000_0000,
		S_OUT  = 12'b1000_0000_0000
	} state_t;

	// Arithmetic shift right by the fraction width, rounding half up.
	function automatic logic signed [ProdW-1:0] rnd_shr(input logic signed [ProdW-1:0] x);
		logic signed [ProdW-1:0] s;
		s = x + (ProdW'(1) <<< (FracW - 1));
		return s >>> FracW;
	endfunction

endpackage

[rtl/cubic_hermite_keyframe_blend.sv]
`timescale 1ns / 1ps
// A translation or scale transaction raises one result; the next one is taken only after
// that result is accepted. A rotation component that does not close a group raises no result.
// A fourth one raises four results, after a 33-step square root and a 17-step restoring divide
// for the first and another divide for each of the rest; a zero-length group raises zeros.
// One transaction is in flight at a time around the one shared 34x34 multiplier. Reset clears
// the sequencer, count, square sum and valid.
module cubic_hermite_keyframe_blend (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  chkb_pkg::in_item_t in_data,
	output logic               out_valid,
	input  logic               out_ready,
	output chkb_pkg::out_item_t out_data
);

	chkb_pkg::state_t state_q;
	chkb_pkg::in_item_t item_q;
	logic [chkb_pkg::PhW-1:0] ph_q, t2_q, t3_q;
	logic signed [chkb_pkg::ProdW-1:0] acc_q;
	logic signed [51:0] base_q;
	logic signed [chkb_pkg::MulW-1:0] tr_q;
	logic signed [chkb_pkg::ValW-1:0] v_q;
	logic signed [chkb_pkg::ValW-1:0] buf_q [4];
	logic [1:0] cnt_q, k_q;
	logic [chkb_pkg::SumW-1:0] sum_q;
	logic [chkb_pkg::RootW-1:0] root_q;
	logic [chkb_pkg::StepW-1:0] step_q;
	logic [chkb_pkg::MulW-1:0] rem_q;
	logic [chkb_pkg::DivSteps-1:0] nq_q;
	logic neg_q, zero_q, grp_q;
	logic out_valid_q;
	chkb_pkg::out_item_t out_q;

	// Hermite weights from the rounded powers of the phase.
	logic signed [chkb_pkg::WgtW-1:0] t1_w, t2_w, t3_w, h00, h10, h01, h11;
	assign t1_w = chkb_pkg::WgtW'(ph_q);
	assign t2_w = chkb_pkg::WgtW'(t2_q);
	assign t3_w = chkb_pkg::WgtW'(t3_q);
	assign h00 = chkb_pkg::WgtW'(2) * t3_w - chkb_pkg::WgtW'(3) * t2_w
		+ chkb_pkg::WgtW'(chkb_pkg::PhOne);
	assign h10 = t3_w - chkb_pkg::WgtW'(2) * t2_w + t1_w;
	assign h01 = chkb_pkg::WgtW'(3) * t2_w - chkb_pkg::WgtW'(2) * t3_w;
	assign h11 = t3_w - t2_w;

	// Shared multiplier operand selection.
	logic signed [chkb_pkg::MulW-1:0] mul_a, mul_b;
	logic signed [chkb_pkg::ProdW-1:0] prod;
	logic [chkb_pkg::RootW-1:0] root_try;
	assign root_try = root_q | (chkb_pkg::RootW'(1) << step_q);

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			chkb_pkg::S_T2: begin
				mul_a = chkb_pkg::MulW'(ph_q);
				mul_b = chkb_pkg::MulW'(ph_q);
			end
			chkb_pkg::S_T3: begin
				mul_a = chkb_pkg::MulW'(t2_q);
				mul_b = chkb_pkg::MulW'(ph_q);
			end
			chkb_pkg::S_P0: begin
				mul_a = chkb_pkg::MulW'(item_q.start_value);
				mul_b = chkb_pkg::MulW'(h00);
			end
			chkb_pkg::S_P1: begin
				mul_a = chkb_pkg::MulW'(item_q.end_value);
				mul_b = chkb_pkg::MulW'(h01);
			end
			chkb_pkg::S_M0: begin
				mul_a = chkb_pkg::MulW'(item_q.out_tangent);
				mul_b = chkb_pkg::MulW'(h10);
			end
			chkb_pkg::S_M1: begin
				mul_a = chkb_pkg::MulW'(item_q.in_tangent);
				mul_b = chkb_pkg::MulW'(h11);
			end
			chkb_pkg::S_SC: begin
				mul_a = tr_q;
				mul_b = signed'(chkb_pkg::MulW'(item_q.tangent_scale));
			end
			chkb_pkg::S_SQ: begin
				mul_a = chkb_pkg::MulW'(v_q);
				mul_b = chkb_pkg::MulW'(v_q);
			end
			chkb_pkg::S_ROOT: begin
				mul_a = signed'(chkb_pkg::MulW'(root_try));
				mul_b = signed'(chkb_pkg::MulW'(root_try));
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign prod = mul_a * mul_b;

	// Rounded sums for the blend.
	logic signed [chkb_pkg::ProdW-1:0] pair_rnd, tan_rnd;
	logic signed [53:0] total;
	logic signed [chkb_pkg::ValW-1:0] blended;
	logic [chkb_pkg::ProdW-1:0] t_rnd;
	assign pair_rnd = chkb_pkg::rnd_shr(acc_q + prod);
	assign tan_rnd = chkb_pkg::rnd_shr(prod);
	assign t_rnd = chkb_pkg::ProdW'(prod) + (chkb_pkg::ProdW'(1) << (chkb_pkg::FracW - 1));
	assign total = 54'(base_q) + tan_rnd[53:0];

	always_comb begin
		if (total > 54'sd2147483647) begin
			blended = 32'sh7fff_ffff;
		end else if (total < -54'sd2147483648) begin
			blended = 32'sh8000_0000;
		end else begin
			blended = total[chkb_pkg::ValW-1:0];
		end
	end

	// Square sum including the current rotation component.
	logic [chkb_pkg::SumW-1:0] sum_next;
	assign sum_next = sum_q + chkb_pkg::SumW'(prod[63:0]);

	// Divider setup for the next component to normalize.
	logic [1:0] div_idx;
	logic signed [chkb_pkg::ValW-1:0] div_q;
	logic [chkb_pkg::ValW-1:0] div_mag;
	logic [chkb_pkg::NumW-1:0] div_num;
	assign div_idx = (state_q == chkb_pkg::S_ROOT) ? 2'd0 : k_q + 2'd1;
	assign div_q = buf_q[div_idx];
	assign div_mag = div_q[chkb_pkg::ValW-1] ? chkb_pkg::ValW'(-div_q) : chkb_pkg::ValW'(div_q);
	assign div_num = (chkb_pkg::NumW'(div_mag) << chkb_pkg::FracW)
		+ chkb_pkg::NumW'(root_q >> 1);

	// One restoring divide step.
	logic [chkb_pkg::MulW-1:0] trial;
	logic trial_ge;
	assign trial = {rem_q[chkb_pkg::MulW-2:0], nq_q[chkb_pkg::DivSteps-1]};
	assign trial_ge = trial >= chkb_pkg::MulW'(root_q);

	logic [chkb_pkg::DivSteps-1:0] quo_next;
	logic signed [chkb_pkg::ValW-1:0] norm_val;
	assign quo_next = {nq_q[chkb_pkg::DivSteps-2:0], trial_ge};
	assign norm_val = neg_q ? -chkb_pkg::ValW'(quo_next) : chkb_pkg::ValW'(quo_next);

	// Group storage, written once per rotation component.
	always_ff @(posedge clk) begin
		if (state_q == chkb_pkg::S_SQ) begin
			buf_q[cnt_q] <= v_q;
		end
	end

	// Sequencer and datapath registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= chkb_pkg::S_IDLE;
			cnt_q       <= '0;
			sum_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				chkb_pkg::S_IDLE: begin
					if (in_valid) begin
						item_q  <= in_data;
						ph_q    <= (in_data.phase > chkb_pkg::PhOne) ? chkb_pkg::PhOne
							: in_data.phase;
						state_q <= chkb_pkg::S_T2;
					end
				end
				chkb_pkg::S_T2: begin
					t2_q    <= t_rnd[chkb_pkg::FracW +: chkb_pkg::PhW];
					state_q <= chkb_pkg::S_T3;
				end
				chkb_pkg::S_T3: begin
					t3_q    <= t_rnd[chkb_pkg::FracW +: chkb_pkg::PhW];
					state_q <= chkb_pkg::S_P0;
				end
				chkb_pkg::S_P0: begin
					acc_q   <= prod;
					state_q <= chkb_pkg::S_P1;
				end
				chkb_pkg::S_P1: begin
					base_q  <= pair_rnd[51:0];
					state_q <= chkb_pkg::S_M0;
				end
				chkb_pkg::S_M0: begin
					acc_q   <= prod;
					state_q <= chkb_pkg::S_M1;
				end
				chkb_pkg::S_M1: begin
					tr_q    <= pair_rnd[chkb_pkg::MulW-1:0];
					state_q <= chkb_pkg::S_SC;
				end
				chkb_pkg::S_SC: begin
					v_q <= blended;
					if (item_q.is_rotation) begin
						state_q <= chkb_pkg::S_SQ;
					end else begin
						grp_q       <= 1'b0;
						out_q       <= '{value: blended, last: 1'b1, zero_norm: 1'b0};
						out_valid_q <= 1'b1;
						state_q     <= chkb_pkg::S_OUT;
					end
				end
				chkb_pkg::S_SQ: begin
					if (cnt_q != 2'd3) begin
						cnt_q   <= cnt_q + 2'd1;
						sum_q   <= sum_next;
						state_q <= chkb_pkg::S_IDLE;
					end else begin
						cnt_q  <= '0;
						sum_q  <= '0;
						grp_q  <= 1'b1;
						k_q    <= '0;
						zero_q <= (sum_next == '0);
						if (sum_next == '0) begin
							out_q       <= '{value: '0, last: 1'b0, zero_norm: 1'b1};
							out_valid_q <= 1'b1;
							state_q     <= chkb_pkg::S_OUT;
						end else begin
							acc_q   <= signed'(chkb_pkg::ProdW'(sum_next));
							root_q  <= '0;
							step_q  <= chkb_pkg::StepW'(chkb_pkg::RootW - 1);
							state_q <= chkb_pkg::S_ROOT;
						end
					end
				end
				chkb_pkg::S_ROOT: begin
					// The full square sum is parked in the accumulator.
					if (prod[66:0] <= acc_q[66:0]) begin
						root_q <= root_try;
					end
					if (step_q == '0) begin
						neg_q   <= div_q[chkb_pkg::ValW-1];
						rem_q   <= chkb_pkg::MulW'(div_num >> chkb_pkg::DivSteps);
						nq_q    <= div_num[chkb_pkg::DivSteps-1:0];
						step_q  <= chkb_pkg::StepW'(chkb_pkg::DivSteps - 1);
						state_q <= chkb_pkg::S_DIV;
					end else begin
						step_q <= step_q - 1'b1;
					end
				end
				chkb_pkg::S_DIV: begin
					rem_q <= trial_ge ? trial - chkb_pkg::MulW'(root_q) : trial;
					nq_q  <= quo_next;
					if (step_q == '0) begin
						out_q       <= '{value: norm_val, last: (k_q == 2'd3), zero_norm: 1'b0};
						out_valid_q <= 1'b1;
						state_q     <= chkb_pkg::S_OUT;
					end else begin
						step_q <= step_q - 1'b1;
					end
				end
				chkb_pkg::S_OUT: begin
					if (out_ready) begin
						if (grp_q && k_q != 2'd3) begin
							k_q <= k_q + 2'd1;
							if (zero_q) begin
								out_q <= '{value: '0, last: (k_q == 2'd2), zero_norm: 1'b1};
							end else begin
								out_valid_q <= 1'b0;
								neg_q       <= div_q[chkb_pkg::ValW-1];
								rem_q       <= chkb_pkg::MulW'(div_num >> chkb_pkg::DivSteps);
								nq_q        <= div_num[chkb_pkg::DivSteps-1:0];
								step_q      <= chkb_pkg::StepW'(chkb_pkg::DivSteps - 1);
								state_q     <= chkb_pkg::S_DIV;
							end
						end else begin
							out_valid_q <= 1'b0;
							state_q     <= chkb_pkg::S_IDLE;
						end
					end
				end
				default: begin
					state_q <= chkb_pkg::S_IDLE;
				end
			endcase
		end
	end

	assign in_ready  = (state_q == chkb_pkg::S_IDLE);
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

`ifndef SYNTHESIS
	// No new transaction is taken while a result is still offered.
	a_ready_excl: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> !out_valid) else $error("input ready while result pending");

	// A zero-length group always reports zero values.
	a_zero_value: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_data.zero_norm) |-> (out_data.value == '0))
		else $error("zero_norm result with nonzero value");

	// After a result that is not the last, more results follow before new input.
	a_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_ready && !out_data.last) |=> !in_ready)
		else $error("input ready inside a rotation group");
`endif

endmodule
